>>> hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_RESERVED   = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // broadcast from the top to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t entry;
  } cell_cmd_t;

endpackage

>>> hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted store. Keeps its entry, takes the new item, or
// takes its neighbor's entry to open or close a gap.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               prev_ge,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output logic               ge,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_r;

  // stays ahead of the new item when its priority is greater or equal
  assign ge    = occupied && (entry_r.prio >= cmd.entry.prio);
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (!ge) begin
        entry_r <= prev_ge ? cmd.entry : prev_entry;
      end
    end else if (cmd.rem) begin
      entry_r <= next_entry;
    end
  end

endmodule

>>> hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held sorted by descending priority in a row of
// cells. Every cell compares its priority with the new item in parallel, so
// one insert or remove is taken each clock: busy stays low and an item is
// accepted whenever start is high. Its result appears one cycle later with
// out_valid high for that single cycle and must be captured then, as the
// receiver cannot stall the block. Equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_req_type,
  input  logic signed [spq_pkg::DATA_W-1:0]      in_item_value,
  input  logic signed [spq_pkg::DATA_W-1:0]      in_item_priority,
  output logic                                   out_valid,
  output logic signed [spq_pkg::DATA_W-1:0]      out_head_value,
  output logic signed [spq_pkg::DATA_W-1:0]      out_head_priority,
  output logic [1:0]                             out_status,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]       out_occupancy
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               valid_r;
  spq_pkg::entry_t    head_r, head_nxt;
  spq_pkg::status_t   status_r, status_nxt;

  logic               accept, is_ins, is_rem, full, empty;
  spq_pkg::cell_cmd_t cmd;

  spq_pkg::entry_t    entries [QUEUE_DEPTH];
  logic               ge      [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_ins = accept && (spq_pkg::req_t'(in_req_type) == spq_pkg::REQ_INSERT);
  assign is_rem = accept && (spq_pkg::req_t'(in_req_type) == spq_pkg::REQ_REMOVE);
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);

  assign cmd.ins        = is_ins && !full;
  assign cmd.rem        = is_rem && !empty;
  assign cmd.entry.val  = in_item_value;
  assign cmd.entry.prio = in_item_priority;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (CNT_W'(gi) < count_r),
        .prev_ge    ((gi == 0) ? 1'b1 : ge[(gi == 0) ? 0 : gi-1]),
        .prev_entry (entries[(gi == 0) ? 0 : gi-1]),
        .next_entry (entries[(gi == QUEUE_DEPTH-1) ? gi : gi+1]),
        .ge         (ge[gi]),
        .entry      (entries[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    head_nxt   = '0;
    status_nxt = spq_pkg::ST_DONE;
    if (is_ins && full) begin
      status_nxt = spq_pkg::ST_FULL;
    end else if (is_rem && empty) begin
      status_nxt = spq_pkg::ST_EMPTY;
    end else if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
      head_nxt  = entries[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    head_r   <= head_nxt;
    status_r <= status_nxt;
  end

  assign out_valid         = valid_r;
  assign out_head_value    = head_r.val;
  assign out_head_priority = head_r.prio;
  assign out_status        = status_r;
  assign out_occupancy     = count_r;

endmodule
